// ----- design/median_radius_point_filter_assert.svh -----
// Assertion macros shared by the median radius point filter RTL.
`ifndef MEDIAN_RADIUS_POINT_FILTER_ASSERT_SVH
`define MEDIAN_RADIUS_POINT_FILTER_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define MRPF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define MRPF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/mrpf_pkg.sv -----
// Shared types and constants of the median radius point filter.
package mrpf_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 12;
    localparam int RADIUS_W = 12;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd250;
    localparam logic REG_KEEP_RADIUS = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R2,
        ST_MC,
        ST_ML,
        ST_MJ,
        ST_MA,
        ST_MD,
        ST_FR,
        ST_FD,
        ST_FS,
        ST_FC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic store;
        logic r2_load;
        logic clr_i;
        logic inc_i;
        logic clr_j;
        logic inc_j;
        logic rd_sel_j;
        logic med_start;
        logic cand_load;
        logic med_acc;
        logic med_check;
        logic abs_load;
        logic sq_load;
        logic mark_keep;
        logic clr_any;
        logic out_load;
        logic out_none;
        logic clear_run;
    } cmd_t;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic keep;
        logic any_keep;
        logic is_last_keep;
        logic out_last;
    } stat_t;
endpackage

// ----- design/mrpf_datapath.sv -----
// Datapath: point store, median counting, distance test and result register.
module mrpf_datapath #(
    parameter int MAX_POINTS = mrpf_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mrpf_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrpf_pkg::cmd_t                cmd,
    output mrpf_pkg::stat_t               stat,
    input  logic [COORD_BITS-1:0]         point_x,
    input  logic [COORD_BITS-1:0]         point_y,
    input  logic [mrpf_pkg::RADIUS_W-1:0] keep_radius,
    output logic [COORD_BITS-1:0]         kept_x,
    output logic [COORD_BITS-1:0]         kept_y,
    output logic                          kept_valid,
    output logic [COORD_BITS-1:0]         center_x,
    output logic [COORD_BITS-1:0]         center_y,
    output logic                          overflowed,
    output logic                          run_end
);
    import mrpf_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int R2_W  = 2 * RADIUS_W;
    localparam int DW    = ((SQ_W + 1) > R2_W) ? (SQ_W + 1) : R2_W;

    logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] mem_y [MAX_POINTS];

    logic [CNT_W-1:0]      count_reg;
    logic                  ovf_reg;
    logic [IDX_W-1:0]      i_reg, j_reg, last_idx_reg;
    logic                  any_reg;
    logic [COORD_BITS-1:0] rd_x_reg, rd_y_reg, cand_x_reg, cand_y_reg;
    logic [COORD_BITS-1:0] med_x_reg, med_y_reg, dx_reg, dy_reg;
    logic [CNT_W-1:0]      less_x_reg, le_x_reg, less_y_reg, le_y_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [R2_W-1:0]       r2_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic [CNT_W-1:0]      half;
    logic [DW-1:0]         dist_sum;

    assign rd_addr  = cmd.rd_sel_j ? j_reg : i_reg;
    assign half     = count_reg >> 1;
    assign dist_sum = DW'(sqx_reg) + DW'(sqy_reg);

    assign stat.i_last       = (CNT_W'(i_reg) + CNT_W'(1)) == count_reg;
    assign stat.j_last       = (CNT_W'(j_reg) + CNT_W'(1)) == count_reg;
    assign stat.keep         = dist_sum < DW'(r2_reg);
    assign stat.any_keep     = any_reg;
    assign stat.is_last_keep = i_reg == last_idx_reg;
    assign stat.out_last     = run_end;

    // store write port and registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store && (count_reg < CNT_W'(MAX_POINTS)))
        begin
            mem_x[count_reg[IDX_W-1:0]] <= point_x;
            mem_y[count_reg[IDX_W-1:0]] <= point_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.store)
            begin
                if (count_reg < CNT_W'(MAX_POINTS))
                    count_reg <= count_reg + CNT_W'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.clear_run)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.clr_i)
                i_reg <= '0;
            else if (cmd.inc_i)
                i_reg <= i_reg + IDX_W'(1);
            if (cmd.clr_j)
                j_reg <= '0;
            else if (cmd.inc_j)
                j_reg <= j_reg + IDX_W'(1);
            if (cmd.clr_any)
                any_reg <= 1'b0;
            else if (cmd.mark_keep && stat.keep)
                any_reg <= 1'b1;
        end
    end

    // median by rank counting, distance pipeline, result register
    always_ff @(posedge clk)
    begin
        if (cmd.r2_load)
            r2_reg <= R2_W'(keep_radius) * R2_W'(keep_radius);
        if (cmd.cand_load)
        begin
            cand_x_reg <= rd_x_reg;
            cand_y_reg <= rd_y_reg;
        end
        if (cmd.med_start)
        begin
            less_x_reg <= '0;
            le_x_reg   <= '0;
            less_y_reg <= '0;
            le_y_reg   <= '0;
        end
        else if (cmd.med_acc)
        begin
            if (rd_x_reg < cand_x_reg)
                less_x_reg <= less_x_reg + CNT_W'(1);
            if (rd_x_reg <= cand_x_reg)
                le_x_reg <= le_x_reg + CNT_W'(1);
            if (rd_y_reg < cand_y_reg)
                less_y_reg <= less_y_reg + CNT_W'(1);
            if (rd_y_reg <= cand_y_reg)
                le_y_reg <= le_y_reg + CNT_W'(1);
        end
        if (cmd.med_check)
        begin
            if ((less_x_reg <= half) && (le_x_reg > half))
                med_x_reg <= cand_x_reg;
            if ((less_y_reg <= half) && (le_y_reg > half))
                med_y_reg <= cand_y_reg;
        end
        if (cmd.abs_load)
        begin
            dx_reg <= (rd_x_reg >= med_x_reg) ? rd_x_reg - med_x_reg : med_x_reg - rd_x_reg;
            dy_reg <= (rd_y_reg >= med_y_reg) ? rd_y_reg - med_y_reg : med_y_reg - rd_y_reg;
        end
        if (cmd.sq_load)
        begin
            sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        end
        if (cmd.mark_keep && stat.keep)
            last_idx_reg <= i_reg;
        if (cmd.out_load)
        begin
            kept_x     <= cmd.out_none ? '0 : rd_x_reg;
            kept_y     <= cmd.out_none ? '0 : rd_y_reg;
            kept_valid <= !cmd.out_none;
            center_x   <= med_x_reg;
            center_y   <= med_y_reg;
            overflowed <= ovf_reg;
            run_end    <= cmd.out_none ? 1'b1 : stat.is_last_keep;
        end
    end
endmodule

// ----- design/mrpf_ctrl.sv -----
// Controller state machine: load, median search, two filter passes, output.
module mrpf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            final_point,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  mrpf_pkg::stat_t stat,
    output mrpf_pkg::cmd_t  cmd
);
    import mrpf_pkg::*;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && final_point) state_next = ST_R2;
            ST_R2:   state_next = ST_MC;
            ST_MC:   state_next = ST_ML;
            ST_ML:   state_next = ST_MJ;
            ST_MJ:   state_next = ST_MA;
            ST_MA:   state_next = stat.j_last ? ST_MD : ST_MJ;
            ST_MD:
            begin
                state_next = ST_MC;
                if (stat.i_last)
                begin
                    state_next = ST_FR;
                    pass_next  = 1'b0;
                end
            end
            ST_FR:   state_next = ST_FD;
            ST_FD:   state_next = ST_FS;
            ST_FS:   state_next = ST_FC;
            ST_FC:
            begin
                if (!pass_reg)
                begin
                    if (stat.i_last)
                    begin
                        pass_next  = 1'b1;
                        state_next = (stat.any_keep || stat.keep) ? ST_FR : ST_OUT;
                    end
                    else
                        state_next = ST_FR;
                end
                else if (stat.keep)
                    state_next = ST_OUT;
                else
                    state_next = stat.i_last ? ST_IDLE : ST_FR;
            end
            ST_OUT:
                if (!out_stall)
                    state_next = stat.out_last ? ST_IDLE : ST_FR;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.store = in_valid;
            end
            ST_R2:
            begin
                cmd.r2_load = 1'b1;
                cmd.clr_i   = 1'b1;
            end
            ST_MC:
            begin
                cmd.clr_j     = 1'b1;
                cmd.med_start = 1'b1;
            end
            ST_ML:   cmd.cand_load = 1'b1;
            ST_MJ:   cmd.rd_sel_j = 1'b1;
            ST_MA:
            begin
                cmd.med_acc = 1'b1;
                cmd.inc_j   = 1'b1;
            end
            ST_MD:
            begin
                cmd.med_check = 1'b1;
                cmd.clr_i     = stat.i_last;
                cmd.inc_i     = 1'b1;
                cmd.clr_any   = 1'b1;
            end
            ST_FR:   ;
            ST_FD:   cmd.abs_load = 1'b1;
            ST_FS:   cmd.sq_load = 1'b1;
            ST_FC:
            begin
                if (!pass_reg)
                begin
                    cmd.mark_keep = 1'b1;
                    cmd.clr_i     = stat.i_last;
                    cmd.inc_i     = 1'b1;
                    if (stat.i_last && !(stat.any_keep || stat.keep))
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_none = 1'b1;
                    end
                end
                else if (stat.keep)
                    cmd.out_load = 1'b1;
                else
                begin
                    cmd.inc_i     = 1'b1;
                    cmd.clear_run = stat.i_last;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.inc_i     = 1'b1;
                    cmd.clear_run = stat.out_last;
                end
            end
            default: ;
        endcase
    end
endmodule

// ----- design/median_radius_point_filter.sv -----
// Top level of the median radius point filter with its register port.
// Usage:
//  Input channel (in_valid/in_stall) carries one point per beat; final_point
//  closes the set. Points load at one beat per cycle while the block is idle.
//  Points past the store depth are dropped and reported as overflowed.
//  After the final beat in_stall rises and the block finds median x and y by
//  rank counting over the store, one memory read port, each stored point
//  a candidate against all. Then two filter passes run, per point (read,
//  abs difference, squares, compare): the first finds the last survivor,
//  the second emits. Output channel (out_valid/out_stall) gives each kept
//  point in input order, with the medians, overflow and run_end on the last
//  beat. With no survivor one beat with kept_valid low is given. A stalled
//  result simply holds; the walk resumes when it is taken. in_stall drops
//  once the run is done. keep_radius must be written over the APB port at
//  byte address 0 only while idle; the block does not enforce it. Reset
//  empties the store count, clears overflow, radius returns to 250.
module median_radius_point_filter #(
    parameter int MAX_POINTS = mrpf_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mrpf_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic                  final_point,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] kept_x,
    output logic [COORD_BITS-1:0] kept_y,
    output logic                  kept_valid,
    output logic [COORD_BITS-1:0] center_x,
    output logic [COORD_BITS-1:0] center_y,
    output logic                  overflowed,
    output logic                  run_end
);
    import mrpf_pkg::*;
    `include "median_radius_point_filter_assert.svh"

    logic [RADIUS_W-1:0] keep_radius_reg;
    cmd_t                cmd;
    stat_t               stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEEP_RADIUS) ? 32'(keep_radius_reg) : 32'd0;

    // register write lands in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keep_radius_reg <= RADIUS_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_KEEP_RADIUS))
            keep_radius_reg <= pwdata[RADIUS_W-1:0];
    end

    mrpf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .final_point (final_point),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    mrpf_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .point_x     (point_x),
        .point_y     (point_y),
        .keep_radius (keep_radius_reg),
        .kept_x      (kept_x),
        .kept_y      (kept_y),
        .kept_valid  (kept_valid),
        .center_x    (center_x),
        .center_y    (center_y),
        .overflowed  (overflowed),
        .run_end     (run_end)
    );

    // input is closed while any result of the run is pending
    `MRPF_ASSERT_IMP(a_out_blocks_in, out_valid, in_stall, "input open during output")
    // the final beat closes the input channel
    `MRPF_ASSERT_NXT(a_final_closes, in_valid && !in_stall && final_point, in_stall,
        "input open after final point")
    // the last beat of a run ends output
    `MRPF_ASSERT_NXT(a_run_end_done, out_valid && !out_stall && run_end, !out_valid,
        "output continued after run end")
endmodule

// ----- tb/median_radius_point_filter_tb.sv -----
// Self-checking testbench for the median radius point filter.
module median_radius_point_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrpf_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam int CW   = COORD_BITS_DEF;

    // One output beat as the checker sees it.
    typedef struct {
        logic [CW-1:0] kx;
        logic [CW-1:0] ky;
        logic          kv;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic          ov;
        logic          last;
    } kept_beat_t;

    // Directed stimulus row. A radius of -1 leaves the register alone;
    // a typed expectation replaces the predicted beat of that row.
    typedef struct {
        int            radius;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          fin;
        logic          typed;
        kept_beat_t    want;
    } point_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CW-1:0] point_x = '0, point_y = '0;
    logic final_point = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CW-1:0] kept_x, kept_y, center_x, center_y;
    logic kept_valid, overflowed, run_end;

    median_radius_point_filter u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .final_point(final_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .kept_x(kept_x), .kept_y(kept_y), .kept_valid(kept_valid),
        .center_x(center_x), .center_y(center_y),
        .overflowed(overflowed), .run_end(run_end)
    );

    always #10 clk = ~clk;

    // Predictor state: shadow of the point store, count, overflow and radius.
    logic [CW-1:0] shadow_x [NPTS];
    logic [CW-1:0] shadow_y [NPTS];
    int            shadow_cnt;
    logic          shadow_ovf;
    logic [11:0]   shadow_radius;

    kept_beat_t kept_q[$];
    int  err_count = 0;
    int  beats_sent = 0;
    bit  long_hold_done = 0;

    // Burst/gap state of the sender.
    int  burst_left = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic logic [CW-1:0] median_of(input logic [CW-1:0] v [NPTS], input int n);
        logic [CW-1:0] srt [NPTS];
        logic [CW-1:0] cur;
        int j;
        if (n == 0)
            return '0;
        for (int i = 0; i < n; i++)
        begin
            cur = v[i];
            j = i;
            while (j > 0 && srt[j-1] > cur)
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = cur;
        end
        return srt[n/2];
    endfunction

    // Applies one accepted point; returns the beats of a finished set.
    task automatic filter_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                input logic fin, output kept_beat_t beats[$]);
        logic [CW-1:0] mx, my;
        longint dx, dy, r2;
        kept_beat_t b;
        beats = {};
        if (shadow_cnt < NPTS)
        begin
            shadow_x[shadow_cnt] = x;
            shadow_y[shadow_cnt] = y;
            shadow_cnt++;
        end
        else
            shadow_ovf = 1'b1;
        if (!fin)
            return;
        mx = median_of(shadow_x, shadow_cnt);
        my = median_of(shadow_y, shadow_cnt);
        r2 = longint'(shadow_radius) * longint'(shadow_radius);
        for (int i = 0; i < shadow_cnt; i++)
        begin
            dx = longint'(shadow_x[i]) - longint'(mx);
            dy = longint'(shadow_y[i]) - longint'(my);
            if (dx*dx + dy*dy < r2)
            begin
                b = '{shadow_x[i], shadow_y[i], 1'b1, mx, my, shadow_ovf, 1'b0};
                beats = {beats, b};
            end
        end
        if (beats.size() == 0)
        begin
            b = '{'0, '0, 1'b0, mx, my, shadow_ovf, 1'b1};
            beats = {beats, b};
        end
        else
            beats[$].last = 1'b1;
        shadow_cnt = 0;
        shadow_ovf = 1'b0;
    endtask

    // Drops valid, then waits until every result is in and in_stall is low.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (kept_q.size() == 0);
        do
            @(posedge clk);
        while (in_stall);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_radius(input int value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_KEEP_RADIUS);
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_radius = 12'(value);
    endtask

    // Sends one point beat; expectations are queued once it is taken.
    // The typed form queues the given beat in place of the predicted one.
    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic fin, input bit typed, input kept_beat_t want);
        kept_beat_t beats[$];
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        point_x <= x;
        point_y <= y;
        final_point <= fin;
        do
            @(posedge clk);
        while (in_stall);
        filter_point(x, y, fin, beats);
        if (typed)
            kept_q = {kept_q, want};
        else
            foreach (beats[i]) kept_q = {kept_q, beats[i]};
        beats_sent++;
        // End of burst: lower valid for a random gap.
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                point_x <= 12'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send_plain(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic fin);
        kept_beat_t none;
        none = '{'0, '0, 1'b0, '0, '0, 1'b0, 1'b0};
        send_point(x, y, fin, 1'b0, none);
    endtask

    // Receiver: random stall with quiet stretches, plus one long hold-off
    // in mid run so the block backs up and holds in_stall high.
    initial
    begin : stall_gen
        int mode;
        int span;
        forever
        begin
            if (!long_hold_done && beats_sent > 120)
            begin
                long_hold_done = 1;
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (600) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 40);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Checker: each taken beat against the oldest expectation.
    always @(posedge clk)
    begin
        kept_beat_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (kept_q.size() == 0)
            begin
                report_mismatch("unexpected beat kept_x", kept_x, -1);
            end
            else
            begin
                w = kept_q.pop_front();
                if (kept_x !== w.kx) report_mismatch("kept_x", kept_x, w.kx);
                if (kept_y !== w.ky) report_mismatch("kept_y", kept_y, w.ky);
                if (kept_valid !== w.kv) report_mismatch("kept_valid", kept_valid, w.kv);
                if (center_x !== w.cx) report_mismatch("center_x", center_x, w.cx);
                if (center_y !== w.cy) report_mismatch("center_y", center_y, w.cy);
                if (overflowed !== w.ov) report_mismatch("overflowed", overflowed, w.ov);
                if (run_end !== w.last) report_mismatch("run_end", run_end, w.last);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end

    // Directed rows: extremes, even/odd medians, zero and full radius.
    point_row_t dir_rows[] = '{
        '{-1,   12'd0,    12'd0,    1'b1, 1'b1, '{12'd0, 12'd0, 1'b1, 12'd0, 12'd0, 1'b0, 1'b1}},
        '{-1,   12'd4095, 12'd4095, 1'b1, 1'b1,
          '{12'd4095, 12'd4095, 1'b1, 12'd4095, 12'd4095, 1'b0, 1'b1}},
        '{-1,   12'd0,    12'd0,    1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd4095, 12'd4095, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd10,   12'd10,   1'b1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        // zero radius keeps nothing, not even the center itself
        '{0,    12'd5,    12'd7,    1'b1, 1'b1, '{12'd0, 12'd0, 1'b0, 12'd5, 12'd7, 1'b0, 1'b1}},
        '{4095, 12'd0,    12'd4095, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd4095, 12'd0,    1'b1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{1,    12'd100,  12'd100,  1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd100,  12'd100,  1'b1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd101,  12'd100,  1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd100,  12'd100,  1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd2730, 12'd1365, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{250,  12'd1000, 12'd1000, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd1249, 12'd1000, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd1250, 12'd1000, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{-1,   12'd1000, 12'd1000, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}}
    };

    initial
    begin : main_seq
        int n, cx, cy, spread, pick;
        shadow_cnt = 0;
        shadow_ovf = 1'b0;
        shadow_radius = RADIUS_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].radius >= 0)
            begin
                wait_idle();
                write_radius(dir_rows[i].radius);
            end
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fin,
                       dir_rows[i].typed, dir_rows[i].want);
        end

        // Random sets: mostly small clusters around a center with outliers;
        // a few oversized sets exercise the full store and dropped points.
        for (int s = 0; beats_sent < 250; s++)
        begin
            if (s % 7 == 3)
            begin
                wait_idle();
                pick = $urandom_range(0, 4);
                case (pick)
                    0: write_radius(0);
                    1: write_radius(4095);
                    2: write_radius(1);
                    3: write_radius(250);
                    default: write_radius($urandom_range(0, 4095));
                endcase
            end
            if (s == 5 || s == 20)
                n = NPTS + 1 + $urandom_range(0, 4);
            else if (s == 12)
                n = NPTS;
            else
                n = $urandom_range(1, 9);
            cx = $urandom_range(0, 4095);
            cy = $urandom_range(0, 4095);
            spread = (1 << $urandom_range(0, 10));
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_plain(12'($urandom), 12'($urandom), k == n - 1);
                else
                    send_plain(12'(cx + $urandom_range(0, spread) - spread / 2),
                               12'(cy + $urandom_range(0, spread) - spread / 2),
                               k == n - 1);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (kept_q.size() == 0);
        repeat (200) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
